@@ sv/tlvp_pkg.sv @@
// Shared types and constants for the TLV record parser.
`timescale 1ns / 1ps

package tlvp_pkg;

    localparam int          BYTE_W      = 8;
    localparam int          POS_W       = 16;
    localparam int          TDATA_W     = 56;
    localparam int          FIFO_DEPTH  = 4;
    localparam int          FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int          PADDR_W     = 3;
    localparam logic [7:0]  MAX_REC_RST = 8'd16;
    localparam logic [15:0] POS_LAST    = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_RECORDS = 1'b0;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_OK     = 2'd1,
        KIND_BAD    = 2'd2
    } kind_t;

    // packed so that record_type sits in the lowest bits
    typedef struct packed {
        logic [7:0]  record_count;
        logic [7:0]  record_index;
        logic [15:0] value_offset;
        logic [15:0] record_length;
        logic [7:0]  record_type;
    } payload_t;

    typedef struct packed {
        logic     last_of_run;
        kind_t    kind;
        payload_t payload;
    } result_t;

endpackage

@@ sv/tlv_record_parser_top.sv @@
// TLV record parser: one frame byte per transfer in, records and frame status out.
//
// Takes one frame byte per clock while s_axis_tready is high and splits the frame
// into records (type byte, 16-bit little-endian length, value bytes). Each byte is
// parsed in the cycle of its transfer; its results are registered into a four-entry
// output queue and presented on the master side from its head. A byte may cause up
// to two results (a record and the frame status on the final byte), and the queue
// drains one result per cycle while m_axis_tready is high, so input is taken whenever
// at least two queue slots are free; with the output side ready the block sustains
// one byte per cycle. max_records resets to 16 and is read when a record completes.
// Malformed status means the records already sent for that frame are to be discarded.
`timescale 1ns / 1ps

module tlv_record_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream: tdata = data_byte, tlast = last_byte
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tlast,
    // master stream: tdata = record_type[7:0], record_length[23:8],
    // value_offset[39:24], record_index[47:40], record_count[55:48]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tlvp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,   // kind
    output logic                          m_axis_tlast,   // last_of_run
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlvp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tlvp_pkg::*;

    // configuration
    logic [7:0] max_records_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] value_left_reg, value_left_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] value_begin_reg, value_begin_next;
    logic [7:0]  kept_count_reg, kept_count_next;
    logic        overflow_reg, overflow_next;

    // output queue
    result_t              fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   fifo_cnt_reg, fifo_cnt_next;

    logic        in_xfer, out_xfer;
    logic        pos_at_end;
    logic [15:0] full_length;
    logic [15:0] left_dec;
    logic        rec_done;
    logic        rec_push, stat_push;
    result_t     rec_res, stat_res;
    logic [FIFO_AW-1:0] stat_slot;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_MAX_RECORDS) ? {24'd0, max_records_reg} : 32'd0;

    assign s_axis_tready = (fifo_cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = fifo_mem_reg[rd_ptr_reg].payload;
    assign m_axis_tuser  = fifo_mem_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = fifo_mem_reg[rd_ptr_reg].last_of_run;

    assign pos_at_end  = (byte_position_reg == POS_LAST);
    assign full_length = {s_axis_tdata, held_length_reg[7:0]};
    assign left_dec    = value_left_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_records_reg <= MAX_REC_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_RECORDS))
        begin
            max_records_reg <= pwdata[7:0];
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_xfer)
        begin
            if (!overflow_reg)
            begin
                unique case (phase_reg)
                    PH_TYPE:   phase_next = PH_LEN_LO;
                    PH_LEN_LO: phase_next = PH_LEN_HI;
                    PH_LEN_HI:
                    begin
                        if (!pos_at_end)
                            phase_next = (full_length == '0) ? PH_TYPE : PH_VALUE;
                    end
                    PH_VALUE:
                    begin
                        if (left_dec == '0)
                            phase_next = PH_TYPE;
                    end
                    default:   phase_next = PH_TYPE;
                endcase
            end
            if (s_axis_tlast)
                phase_next = PH_TYPE;
        end
    end

    // datapath and results
    always_comb
    begin
        logic   ovf;
        phase_t ph_after;

        held_type_next     = held_type_reg;
        held_length_next   = held_length_reg;
        value_left_next    = value_left_reg;
        byte_position_next = byte_position_reg;
        value_begin_next   = value_begin_reg;
        kept_count_next    = kept_count_reg;
        overflow_next      = overflow_reg;
        rec_done           = 1'b0;
        ovf                = overflow_reg;
        ph_after           = phase_reg;

        if (in_xfer && !overflow_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    held_type_next = s_axis_tdata;
                    ph_after       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    held_length_next = {8'd0, s_axis_tdata};
                    ph_after         = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    held_length_next = full_length;
                    if (pos_at_end)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        value_begin_next = byte_position_reg + 16'd1;
                        value_left_next  = full_length;
                        rec_done         = (full_length == '0);
                        ph_after         = (full_length == '0) ? PH_TYPE : PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    value_left_next = left_dec;
                    rec_done        = (left_dec == '0);
                    ph_after        = (left_dec == '0) ? PH_TYPE : PH_VALUE;
                end
                default:
                begin
                    ph_after = PH_TYPE;
                end
            endcase
            if (pos_at_end && !s_axis_tlast)
                ovf = 1'b1;
            if (!ovf)
                byte_position_next = byte_position_reg + 16'd1;
            overflow_next = ovf;
        end

        rec_push = rec_done && (kept_count_reg < max_records_reg);
        if (rec_push)
            kept_count_next = kept_count_reg + 8'd1;

        stat_push = in_xfer && s_axis_tlast;

        rec_res                       = '0;
        rec_res.kind                  = KIND_RECORD;
        rec_res.payload.record_type   = held_type_next;
        rec_res.payload.record_length = held_length_next;
        rec_res.payload.value_offset  = value_begin_next;
        rec_res.payload.record_index  = kept_count_reg;
        rec_res.last_of_run           = !stat_push;

        stat_res                      = '0;
        stat_res.kind                 = (ovf || (ph_after != PH_TYPE)) ? KIND_BAD : KIND_OK;
        stat_res.payload.record_count = kept_count_next;
        stat_res.last_of_run          = 1'b1;

        if (stat_push)
        begin
            held_type_next     = '0;
            held_length_next   = '0;
            value_left_next    = '0;
            byte_position_next = '0;
            value_begin_next   = '0;
            kept_count_next    = '0;
            overflow_next      = 1'b0;
        end

        stat_slot     = rec_push ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;
        wr_ptr_next   = wr_ptr_reg + FIFO_AW'(rec_push) + FIFO_AW'(stat_push);
        rd_ptr_next   = rd_ptr_reg + FIFO_AW'(out_xfer);
        fifo_cnt_next = fifo_cnt_reg + FIFO_CW'(rec_push) + FIFO_CW'(stat_push)
                        - FIFO_CW'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TYPE;
            held_type_reg     <= '0;
            held_length_reg   <= '0;
            value_left_reg    <= '0;
            byte_position_reg <= '0;
            value_begin_reg   <= '0;
            kept_count_reg    <= '0;
            overflow_reg      <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            fifo_cnt_reg      <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            held_type_reg     <= held_type_next;
            held_length_reg   <= held_length_next;
            value_left_reg    <= value_left_next;
            byte_position_reg <= byte_position_next;
            value_begin_reg   <= value_begin_next;
            kept_count_reg    <= kept_count_next;
            overflow_reg      <= overflow_next;
            wr_ptr_reg        <= wr_ptr_next;
            rd_ptr_reg        <= rd_ptr_next;
            fifo_cnt_reg      <= fifo_cnt_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (rec_push)
            fifo_mem_reg[wr_ptr_reg] <= rec_res;
        if (stat_push)
            fifo_mem_reg[stat_slot] <= stat_res;
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue count beyond depth");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tlast) |=>
            (phase_reg == PH_TYPE && byte_position_reg == '0 && kept_count_reg == '0
             && !overflow_reg))
        else $error("frame state not cleared after final byte");

    a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (byte_position_reg == POS_LAST))
        else $error("overflow flag set away from last position");

    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |-> (value_left_reg != '0))
        else $error("value phase with nothing left");

endmodule
